// ===== rtl/qfr_pkg.sv =====
// Shared types, widths and arithmetic step functions for the rotation
// matrix to quaternion converter. No dependencies.
`timescale 1ns / 1ps

package qfr_pkg;

  localparam int CompW      = 16;
  localparam int FracW      = CompW - 2;
  localparam int RadW       = CompW + 1;
  localparam int DW         = CompW + 2;
  localparam int MagW       = CompW + 1;
  localparam int RW         = 2 * CompW;
  localparam int SqW        = CompW;
  localparam int NumW       = 2 * CompW - 1;
  localparam int DenW       = CompW + 1;
  localparam int DvW        = 2 * CompW;
  localparam int QW         = CompW - 1;
  localparam int SqPerStage = 2;
  localparam int SqStages   = (SqW + SqPerStage - 1) / SqPerStage;
  localparam int DvPerStage = 3;
  localparam int DvStages   = (QW + DvPerStage - 1) / DvPerStage;

  localparam logic [CompW-1:0] CompMax = {1'b0, {(CompW-1){1'b1}}};
  localparam logic [CompW-1:0] CompMin = {1'b1, {(CompW-1){1'b0}}};

  typedef logic [8:0][CompW-1:0] mat_t;

  typedef struct packed {
    logic [3:0][DW-1:0] d;
    logic [1:0]         main;
    logic               degen;
  } side_t;

  typedef struct packed {
    logic [RadW-1:0] rad;
    side_t           side;
  } fr_t;

  typedef struct packed {
    logic [SqW-1:0] s;
    side_t          side;
  } rt_t;

  typedef struct packed {
    logic [RW-1:0] op;
    logic [RW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [DvW-1:0] rem;
    logic [QW-1:0]  q;
  } dv_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    logic [SqW-1:0]  s;
    logic [3:0]      ovf;
    logic [3:0]      neg;
    logic [1:0]      main;
    logic            degen;
  } qc_t;

  function automatic logic [1:0] succ(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // One iteration of the bit-pair square root; t selects the bit pair.
  function automatic sq_t sq_step(input sq_t a, input int t);
    sq_t           r;
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    r     = a;
    bitv  = RW'(1) << (2 * t);
    trial = a.res + bitv;
    if (a.op >= trial) begin
      r.op  = a.op - trial;
      r.res = (a.res >> 1) + bitv;
    end else begin
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  // One restoring division step for quotient bit b.
  function automatic dv_t dv_step(input dv_t a, input logic [DenW-1:0] den, input int b);
    dv_t            r;
    logic [DvW-1:0] sh;
    r  = a;
    sh = DvW'(den) << b;
    if (a.rem >= sh) begin
      r.rem  = a.rem - sh;
      r.q[b] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/qfr_front.sv =====
// First stage: trace test, diagonal pick, radicand and the scaled sums and
// differences for the three components other than the main one. Depends on qfr_pkg.
`timescale 1ns / 1ps

module qfr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qfr_pkg::mat_t  mat_i,
  output logic           valid_o,
  output qfr_pkg::fr_t   data_o
);
  import qfr_pkg::*;

  logic signed [DW-1:0] me [9];
  logic signed [DW-1:0] trace;
  logic signed [DW-1:0] rad;
  logic [1:0]           i, j, k;
  fr_t                  data_d, data_q;
  logic                 valid_q;

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      me[n] = signed'({{2{mat_i[n][CompW-1]}}, mat_i[n]});
    end
    trace  = me[0] + me[4] + me[8];
    data_d = '0;
    i = 2'd0;
    if (me[4] > me[0]) i = 2'd1;
    if (me[8] > me[{i, 2'b00}]) i = 2'd2;
    j = succ(i);
    k = succ(j);
    if (trace > 0) begin
      rad = trace + DW'(1 << FracW);
      data_d.side.main = 2'd0;
      data_d.side.d[1] = me[7] - me[5];
      data_d.side.d[2] = me[2] - me[6];
      data_d.side.d[3] = me[3] - me[1];
    end else begin
      // Diagonal of row r sits at flat index 4r.
      rad = me[4 * i] - me[4 * j] - me[4 * k] + DW'(1 << FracW);
      data_d.side.main        = i + 2'd1;
      data_d.side.d[0]        = me[3 * k + j] - me[3 * j + k];
      data_d.side.d[j + 2'd1] = me[3 * j + i] + me[3 * i + j];
      data_d.side.d[k + 2'd1] = me[3 * k + i] + me[3 * i + k];
    end
    if (rad > 0) begin
      data_d.rad = rad[RadW-1:0];
    end else begin
      data_d.side.degen = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/qfr_root.sv =====
// Pipelined integer square root, two result bits per stage, with the
// component data carried alongside. Depends on qfr_pkg.
`timescale 1ns / 1ps

module qfr_root (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qfr_pkg::fr_t  data_i,
  output logic          valid_o,
  output qfr_pkg::rt_t  data_o
);
  import qfr_pkg::*;

  sq_t   sq_d   [SqStages];
  sq_t   sq_q   [SqStages];
  side_t side_q [SqStages];
  logic  vld_q  [SqStages];

  always_comb begin
    sq_t a;
    int  t;
    for (int st = 0; st < SqStages; st++) begin
      if (st == 0) begin
        a.op  = RW'(data_i.rad) << FracW;
        a.res = '0;
      end else begin
        a = sq_q[st-1];
      end
      for (int n = 0; n < SqPerStage; n++) begin
        t = SqW - 1 - st * SqPerStage - n;
        if (t >= 0) a = sq_step(a, t);
      end
      sq_d[st] = a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int st = 0; st < SqStages; st++) vld_q[st] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int st = 1; st < SqStages; st++) vld_q[st] <= vld_q[st-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= data_i.side;
      for (int st = 1; st < SqStages; st++) side_q[st] <= side_q[st-1];
      for (int st = 0; st < SqStages; st++) sq_q[st] <= sq_d[st];
    end
  end

  assign valid_o     = vld_q[SqStages-1];
  assign data_o.s    = sq_q[SqStages-1].res[SqW-1:0];
  assign data_o.side = side_q[SqStages-1];

endmodule

// ===== rtl/qfr_quot.sv =====
// Reciprocal scaling: four pipelined restoring dividers, rounding, sign,
// saturation and the final result register. Depends on qfr_pkg.
`timescale 1ns / 1ps

module qfr_quot (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  qfr_pkg::rt_t                 data_i,
  output logic                         valid_o,
  output logic [3:0][qfr_pkg::CompW-1:0] quat_o,
  output logic                         degen_o
);
  import qfr_pkg::*;

  dv_t  dv_d  [DvStages+1][4];
  dv_t  dv_q  [DvStages+1][4];
  qc_t  qc_d;
  qc_t  qc_q  [DvStages+1];
  logic vld_q [DvStages+1];
  logic [3:0][CompW-1:0] quat_d, quat_q;
  logic                  out_vld_q, degen_q;

  always_comb begin
    logic signed [DW-1:0] dv;
    logic [DW-1:0]        mag;
    logic [NumW-1:0]      num;
    dv_t                  a;
    int                   b;
    qc_d.s     = data_i.s;
    qc_d.den   = {data_i.s, 1'b0};
    qc_d.main  = data_i.side.main;
    qc_d.degen = data_i.side.degen;
    for (int c = 0; c < 4; c++) begin
      dv  = signed'(data_i.side.d[c]);
      mag = (dv < 0) ? DW'(-dv) : DW'(dv);
      num = {mag[MagW-1:0], {FracW{1'b0}}} + NumW'(data_i.s);
      qc_d.neg[c]    = dv < 0;
      qc_d.ovf[c]    = DvW'(num) >= (DvW'(qc_d.den) << (CompW - 1));
      dv_d[0][c].rem = DvW'(num);
      dv_d[0][c].q   = '0;
    end
    for (int st = 1; st <= DvStages; st++) begin
      for (int c = 0; c < 4; c++) begin
        a = dv_q[st-1][c];
        for (int n = 0; n < DvPerStage; n++) begin
          b = QW - 1 - (st - 1) * DvPerStage - n;
          if (b >= 0) a = dv_step(a, qc_q[st-1].den, b);
        end
        dv_d[st][c] = a;
      end
    end
  end

  always_comb begin
    qc_t f;
    f = qc_q[DvStages];
    for (int c = 0; c < 4; c++) begin
      if (f.degen) begin
        quat_d[c] = '0;
      end else if (f.main == 2'(c)) begin
        quat_d[c] = CompW'(f.s >> 1);
      end else if (f.ovf[c]) begin
        // Quotient reached the top of the range: clamp by sign.
        quat_d[c] = f.neg[c] ? CompMin : CompMax;
      end else if (f.neg[c]) begin
        quat_d[c] = CompW'(0) - {1'b0, dv_q[DvStages][c].q};
      end else begin
        quat_d[c] = {1'b0, dv_q[DvStages][c].q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int st = 0; st <= DvStages; st++) vld_q[st] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int st = 1; st <= DvStages; st++) vld_q[st] <= vld_q[st-1];
      out_vld_q <= vld_q[DvStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qc_q[0] <= qc_d;
      for (int st = 1; st <= DvStages; st++) qc_q[st] <= qc_q[st-1];
      for (int st = 0; st <= DvStages; st++) begin
        for (int c = 0; c < 4; c++) dv_q[st][c] <= dv_d[st][c];
      end
      quat_q  <= quat_d;
      degen_q <= qc_q[DvStages].degen;
    end
  end

  assign valid_o = out_vld_q;
  assign quat_o  = quat_q;
  assign degen_o = degen_q;

endmodule

// ===== rtl/quaternion_from_rotation_matrix.sv =====
// Top level of the rotation matrix to quaternion converter: front stage,
// square root pipeline and divider pipeline. Depends on qfr_pkg and submodules.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | m00_i .. m22_i
//   out     | output    | out_valid_o/out_stall_i | quat_w_o .. quat_z_o, degenerate_o
//
// One transaction is accepted every cycle unless a valid output is stalled. The
// pipeline holds one front stage, eight square root stages (two root bits each),
// and seven divider stages (preparation, five stages of three quotient bits,
// result register). Reset clears only the valid bits. A stall on a valid output
// freezes every stage at once, so the input is stalled in the same cycle.
`timescale 1ns / 1ps

module quaternion_from_rotation_matrix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [qfr_pkg::CompW-1:0] m00_i,
  input  logic [qfr_pkg::CompW-1:0] m01_i,
  input  logic [qfr_pkg::CompW-1:0] m02_i,
  input  logic [qfr_pkg::CompW-1:0] m10_i,
  input  logic [qfr_pkg::CompW-1:0] m11_i,
  input  logic [qfr_pkg::CompW-1:0] m12_i,
  input  logic [qfr_pkg::CompW-1:0] m20_i,
  input  logic [qfr_pkg::CompW-1:0] m21_i,
  input  logic [qfr_pkg::CompW-1:0] m22_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [qfr_pkg::CompW-1:0] quat_w_o,
  output logic [qfr_pkg::CompW-1:0] quat_x_o,
  output logic [qfr_pkg::CompW-1:0] quat_y_o,
  output logic [qfr_pkg::CompW-1:0] quat_z_o,
  output logic                      degenerate_o
);
  import qfr_pkg::*;

  mat_t                  mat;
  fr_t                   fr_data;
  rt_t                   rt_data;
  logic                  fr_valid, rt_valid, en;
  logic [3:0][CompW-1:0] quat;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign mat = {m22_i, m21_i, m20_i, m12_i, m11_i, m10_i, m02_i, m01_i, m00_i};

  qfr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (mat),
    .valid_o (fr_valid),
    .data_o  (fr_data)
  );

  qfr_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .valid_o (rt_valid),
    .data_o  (rt_data)
  );

  qfr_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_valid),
    .data_i  (rt_data),
    .valid_o (out_valid_o),
    .quat_o  (quat),
    .degen_o (degenerate_o)
  );

  assign quat_w_o = quat[0];
  assign quat_x_o = quat[1];
  assign quat_y_o = quat[2];
  assign quat_z_o = quat[3];

endmodule

// ===== verif/quaternion_from_rotation_matrix_tb.sv =====
// Testbench for the rotation matrix to quaternion converter: directed and random
// matrices, random input gaps and output stalls, checked against a scoreboard class.
// Depends on qfr_pkg and the quaternion_from_rotation_matrix RTL.
`timescale 1ns / 1ps

module quaternion_from_rotation_matrix_tb;
  import qfr_pkg::*;

  localparam int FB = FracW;
  localparam longint QMAX = (64'sd1 <<< (CompW - 1)) - 1;
  localparam longint QMIN = -QMAX - 1;
  localparam longint ONEQ = 64'sd1 <<< FB;
  localparam int WATCHDOG = 4000;
  localparam int NRAND = 1500;

  typedef struct {
    logic [CompW-1:0] w, x, y, z;
    logic             degen;
  } quat_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    errors++;
    $display("ERROR %s: got %0d expected %0d", what, got, exp);
  endtask

  function automatic longint clamp_comp(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint unsigned op);
    longint unsigned res, bv;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > op) bv >>= 2;
    while (bv != 0) begin
      if (op >= res + bv) begin
        op -= res + bv;
        res = (res >> 1) + bv;
      end else begin
        res >>= 1;
      end
      bv >>= 2;
    end
    return res;
  endfunction

  // Scaled d / (2*root), rounded half away from zero.
  function automatic longint recip_scale(input longint d, input longint root);
    longint unsigned den, mag, q;
    den = root << 1;
    mag = (d < 0) ? -d : d;
    q = ((mag << FB) + (den >> 1)) / den;
    if (q > QMAX + 1) q = QMAX + 1;
    return clamp_comp(d < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t convert_matrix(input mat_t mi);
    longint m[3][3];
    longint q[4];
    longint tr, rad, s;
    int i, j, k;
    quat_t r;
    for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'($signed(mi[n]));
    q = '{0, 0, 0, 0};
    r.degen = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      s = int_sqrt((tr + ONEQ) << FB);
      q[0] = clamp_comp(s >> 1);
      q[1] = recip_scale(m[2][1] - m[1][2], s);
      q[2] = recip_scale(m[0][2] - m[2][0], s);
      q[3] = recip_scale(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + ONEQ;
      if (rad <= 0) begin
        r.degen = 1'b1;
      end else begin
        s = int_sqrt(rad << FB);
        q[1 + i] = clamp_comp(s >> 1);
        q[0] = recip_scale(m[k][j] - m[j][k], s);
        q[1 + j] = recip_scale(m[j][i] + m[i][j], s);
        q[1 + k] = recip_scale(m[k][i] + m[i][k], s);
      end
    end
    r.w = CompW'(q[0]); r.x = CompW'(q[1]); r.y = CompW'(q[2]); r.z = CompW'(q[3]);
    return r;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];
    int checked = 0;

    function void note_matrix(input mat_t mi);
      pending.push_back(convert_matrix(mi));
    endfunction

    task check_quat(input quat_t got);
      quat_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, degenerate", got.degen, -1);
      end else begin
        e = pending.pop_front();
        checked++;
        if (got.w !== e.w) report_mismatch("quat_w", $signed(got.w), $signed(e.w));
        if (got.x !== e.x) report_mismatch("quat_x", $signed(got.x), $signed(e.x));
        if (got.y !== e.y) report_mismatch("quat_y", $signed(got.y), $signed(e.y));
        if (got.z !== e.z) report_mismatch("quat_z", $signed(got.z), $signed(e.z));
        if (got.degen !== e.degen) report_mismatch("degenerate", got.degen, e.degen);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, degenerate_o;
  mat_t mat = '0;
  logic [CompW-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  quat_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  always #6 clk_i = ~clk_i;

  quaternion_from_rotation_matrix DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .m00_i(mat[0]), .m01_i(mat[1]), .m02_i(mat[2]),
    .m10_i(mat[3]), .m11_i(mat[4]), .m12_i(mat[5]),
    .m20_i(mat[6]), .m21_i(mat[7]), .m22_i(mat[8]),
    .out_valid_o, .out_stall_i,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o, .degenerate_o
  );

  // Both transactions are sampled at the rising edge; the watchdog counts quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_matrix(mat);
        sent++;
      end
      if (out_valid_o && !out_stall_i)
        sb.check_quat('{quat_w_o, quat_x_o, quat_y_o, quat_z_o, degenerate_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Valid stays high from one transaction into the next when there is no gap.
  task automatic send_matrix(input mat_t mi, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mat <= mi;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  function automatic int draw_gap();
    // About a third of the items come back to back.
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic mat_t rand_entries();
    mat_t r;
    for (int n = 0; n < 9; n++) r[n] = CompW'($urandom());
    return r;
  endfunction

  // Rotation-like matrix: diagonal entries up to one in magnitude, off-diagonals in
  // [-1, 1], with the dominant axis chosen at random so every branch is reached.
  function automatic mat_t rand_rotation();
    mat_t r;
    int ax;
    longint v;
    ax = $urandom_range(0, 3);
    for (int n = 0; n < 9; n++) begin
      if (n % 4 == 0) begin
        if (ax == 3) v = $urandom_range(0, 16384);
        else if (n / 4 == ax) v = $urandom_range(4000, 16384);
        else v = -longint'($urandom_range(0, 16384));
      end else begin
        v = longint'($urandom_range(0, 32768)) - 16384;
      end
      r[n] = CompW'(v);
    end
    return r;
  endfunction

  function automatic mat_t diag_matrix(input int a, input int b, input int c);
    mat_t r;
    r = '0;
    r[0] = CompW'(a); r[4] = CompW'(b); r[8] = CompW'(c);
    return r;
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stalls at random, with one long hold-off on request.
  initial begin
    int hold;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (60) @(negedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (stim_done || $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        hold = draw_gap();
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    mat_t dm;
    int quiet;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Identity, 180 degree turns about each axis, ties and extremes.
    send_matrix(diag_matrix(16384, 16384, 16384), 0);
    send_matrix(diag_matrix(16384, -16384, -16384), 0);
    send_matrix(diag_matrix(-16384, 16384, -16384), 0);
    send_matrix(diag_matrix(-16384, -16384, 16384), 0);
    send_matrix(diag_matrix(0, 0, 0), 1);
    send_matrix(diag_matrix(-5, 5, 0), 0);
    send_matrix(diag_matrix(-100, -100, -100), 0);
    send_matrix(diag_matrix(1, 1, -2), 0);
    send_matrix(diag_matrix(-32768, -32768, -32768), 2);
    send_matrix(diag_matrix(32767, 32767, 32767), 0);
    send_matrix(diag_matrix(32767, -32768, -32768), 0);
    send_matrix(diag_matrix(-32768, 32767, -32768), 0);
    send_matrix(diag_matrix(-32768, -32768, 32767), 0);
    send_matrix(diag_matrix(-16384, -16384, 0), 0);
    for (int n = 0; n < 9; n++) dm[n] = (n % 2) ? 16'h8000 : 16'h7fff;
    send_matrix(dm, 0);
    for (int n = 0; n < 9; n++) dm[n] = (n % 2) ? 16'h7fff : 16'h8000;
    send_matrix(dm, 0);
    dm = diag_matrix(1, 0, 0);
    dm[1] = 16'h8000; dm[3] = 16'h7fff;
    send_matrix(dm, 0);
    dm = diag_matrix(-32768, -32768, -32767);
    dm[5] = 16'h7fff; dm[7] = 16'h8000;
    send_matrix(dm, 0);
    send_matrix('1, 0);
    send_matrix('0, 0);

    for (int n = 0; n < NRAND; n++) begin
      if (n == 300) long_hold = 1'b1;
      if (n == 800) begin
        idle_input();
        wait_drained();
        repeat (20) @(negedge clk_i);
      end
      send_matrix(($urandom_range(0, 3) == 0) ? rand_entries() : rand_rotation(),
                  (n >= 300 && n < 400) ? 0 : draw_gap());
    end
    idle_input();
    stim_done = 1'b1;

    quiet = 0;
    while (sb.pending.size() != 0 && quiet < 2000) begin
      @(negedge clk_i);
      quiet++;
    end
    repeat (40) @(negedge clk_i);
    $display("Sent %0d matrices and checked %0d quaternions across all branches,",
             sent, sb.checked);
    $display("with random stalls on both sides and one long output hold-off.");
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending.size() != 0) $display("%0d results never arrived", sb.pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== quaternion_from_rotation_matrix.f =====
rtl/qfr_pkg.sv
rtl/qfr_front.sv
rtl/qfr_root.sv
rtl/qfr_quot.sv
rtl/quaternion_from_rotation_matrix.sv
verif/quaternion_from_rotation_matrix_tb.sv
